// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file of this project
// depends on nothing; included by files that hold concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, switched off while the synchronous reset is low
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that is checked during reset as well
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/matd_pkg.sv =====
// shared types and constants of the motion amplitude trend detector
// depends on nothing; used by the top level and its checker
`default_nettype none

package matd_pkg;

    // sample and field widths
    localparam int SAMPLE_BITS = 16;
    localparam int COUNT_W     = 9;
    localparam int LIMIT_W     = 8;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int IN_TDATA_W  = 32;
    localparam int OUT_TDATA_W = 56;

    // register reset values
    localparam logic [SAMPLE_BITS-1:0] RST_UP_MARGIN   = SAMPLE_BITS'(30);
    localparam logic [SAMPLE_BITS-1:0] RST_DOWN_MARGIN = SAMPLE_BITS'(30);
    localparam logic [SAMPLE_BITS-1:0] RST_INIT_STEP   = SAMPLE_BITS'(5);
    localparam logic [SAMPLE_BITS-1:0] RST_STEP_INC    = SAMPLE_BITS'(5);
    localparam logic [LIMIT_W-1:0]     RST_FALL_LIMIT  = LIMIT_W'(15);

    // trend codes
    typedef enum logic [1:0] {
        TREND_STABLE   = 2'd0,
        TREND_APPROACH = 2'd1,
        TREND_RECEDE   = 2'd2
    } t_trend;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_UP_MARGIN   = 3'd0,
        REG_DOWN_MARGIN = 3'd1,
        REG_INIT_STEP   = 3'd2,
        REG_STEP_INC    = 3'd3,
        REG_FALL_LIMIT  = 3'd4
    } t_reg_idx;

endpackage

`default_nettype wire

// ===== hdl/motion_amplitude_trend_detector.sv =====
// motion amplitude trend detector: peak hold with growing decay and two averages
// depends on matd_pkg
`default_nettype none

// Usage
// Input stream: one request per window carries the window's largest sample
// (tdata[15:0]) and smallest sample (tdata[31:16]). Output stream: one result
// per request with held amplitude, fast average, slow average and trend code.
// Configuration: write i_cfg_we with a register index and data while no
// request is in flight; indexes past the last register are ignored.
// A request passes through the input register stage and then the result
// register; one request is taken every cycle while the receiver takes each
// result. The amplitude is formed in the input register stage and
// the peak hold, both averages and the trend are updated in one step into the
// result register, so the held state feeds the next request directly.
// When the receiver stalls, the result register holds and one more request
// can wait in the input stage; input ready drops only when both are full.
// Synchronous reset clears the held value, fall count, averages and both
// valid flags, loads the register defaults and sets the decay step to five.
module motion_amplitude_trend_detector (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // configuration write port
    input  wire logic                              i_cfg_we,
    input  wire logic [matd_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [matd_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // input stream
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    // [15:0] window_max, [31:16] window_min
    input  wire logic [matd_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // output stream
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    // [15:0] held_amplitude, [31:16] fast_average, [47:32] slow_average,
    // [49:48] trend, [55:50] zero
    output logic [matd_pkg::OUT_TDATA_W-1:0]       o_m_axis_tdata
);

    localparam int SW = matd_pkg::SAMPLE_BITS;
    localparam int CW = matd_pkg::COUNT_W;
    localparam int LW = matd_pkg::LIMIT_W;
    localparam logic [CW-1:0] COUNT_MAX = '1;
    localparam logic [SW-1:0] FULL_SCALE = '1;
    localparam int PAD_W = matd_pkg::OUT_TDATA_W - 3 * SW - 2;

    // configuration registers
    logic [SW-1:0] r_up_margin;
    logic [SW-1:0] r_down_margin;
    logic [SW-1:0] r_init_step;
    logic [SW-1:0] r_step_inc;
    logic [LW-1:0] r_fall_limit;

    // pipeline control and payload
    logic          r_in_vld;
    logic [SW-1:0] r_amp;
    logic          r_out_vld;
    logic [SW-1:0] r_out_held;
    logic [SW-1:0] r_out_fast;
    logic [SW-1:0] r_out_slow;
    matd_pkg::t_trend r_out_trend;

    // detector state
    logic [SW-1:0] r_held;
    logic [SW-1:0] r_step;
    logic [CW-1:0] r_count;
    logic [SW-1:0] r_fast;
    logic [SW-1:0] r_slow;

    // next values
    logic [SW-1:0] n_held;
    logic [SW-1:0] n_step;
    logic [CW-1:0] n_count;
    logic [SW-1:0] n_fast;
    logic [SW-1:0] n_slow;
    matd_pkg::t_trend n_trend;

    // helpers
    logic          advance;
    logic          in_req;
    logic          fire;
    logic [SW-1:0] win_max;
    logic [SW-1:0] win_min;
    logic [SW-1:0] amp_in;
    logic [SW:0]   step_sum;
    logic [CW-1:0] count_inc;
    logic [SW+1:0] fast_sum;
    logic [SW+3:0] slow_sum;
    logic [SW:0]   up_sum;
    logic [SW:0]   down_sum;

    // handshake: result stage moves when empty or taken
    assign advance         = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_vld || advance;
    assign in_req          = i_s_axis_tvalid && o_s_axis_tready;
    assign fire            = r_in_vld && advance;

    // amplitude of the incoming window
    assign win_max = i_s_axis_tdata[SW-1:0];
    assign win_min = i_s_axis_tdata[2*SW-1:SW];
    assign amp_in  = (win_max >= win_min) ? (win_max - win_min) : (win_min - win_max);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_margin   <= matd_pkg::RST_UP_MARGIN;
            r_down_margin <= matd_pkg::RST_DOWN_MARGIN;
            r_init_step   <= matd_pkg::RST_INIT_STEP;
            r_step_inc    <= matd_pkg::RST_STEP_INC;
            r_fall_limit  <= matd_pkg::RST_FALL_LIMIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                matd_pkg::REG_UP_MARGIN:   r_up_margin   <= i_cfg_wdata;
                matd_pkg::REG_DOWN_MARGIN: r_down_margin <= i_cfg_wdata;
                matd_pkg::REG_INIT_STEP:   r_init_step   <= i_cfg_wdata;
                matd_pkg::REG_STEP_INC:    r_step_inc    <= i_cfg_wdata;
                matd_pkg::REG_FALL_LIMIT:  r_fall_limit  <= i_cfg_wdata[LW-1:0];
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_req) begin
            r_amp <= amp_in;
        end
    end

    // peak hold with accelerating decay
    assign step_sum  = {1'b0, r_step} + {1'b0, r_step_inc};
    assign count_inc = (r_count == COUNT_MAX) ? r_count : r_count + CW'(1);

    always_comb begin
        n_held  = r_held;
        n_step  = r_step;
        n_count = r_count;
        if (r_amp >= r_held) begin
            n_held  = r_amp;
            n_step  = r_init_step;
            n_count = '0;
        end else if (r_held >= r_step) begin
            n_held  = r_held - r_step;
            n_count = count_inc;
            if (count_inc > {1'b0, r_fall_limit}) begin
                n_step = step_sum[SW] ? FULL_SCALE : step_sum[SW-1:0];
            end
        end else begin
            n_held = '0;
        end
    end

    // truncating averages: 3/4 old plus 1/4 new, 15/16 old plus 1/16 new
    assign fast_sum = {1'b0, r_fast, 1'b0} + {2'b0, r_fast} + {2'b0, n_held};
    assign slow_sum = {r_slow, 4'b0} - {4'b0, r_slow} + {4'b0, n_held};
    assign n_fast   = fast_sum[SW+1:2];
    assign n_slow   = slow_sum[SW+3:4];

    // trend from the two averages at full width
    assign up_sum   = {1'b0, n_slow} + {1'b0, r_up_margin};
    assign down_sum = {1'b0, n_fast} + {1'b0, r_down_margin};

    always_comb begin
        if ({1'b0, n_fast} > up_sum) begin
            n_trend = matd_pkg::TREND_APPROACH;
        end else if (down_sum < {1'b0, n_slow}) begin
            n_trend = matd_pkg::TREND_RECEDE;
        end else begin
            n_trend = matd_pkg::TREND_STABLE;
        end
    end

    // state update when a request moves into the result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held  <= '0;
            r_step  <= matd_pkg::RST_INIT_STEP;
            r_count <= '0;
            r_fast  <= '0;
            r_slow  <= '0;
        end else if (fire) begin
            r_held  <= n_held;
            r_step  <= n_step;
            r_count <= n_count;
            r_fast  <= n_fast;
            r_slow  <= n_slow;
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_held  <= n_held;
            r_out_fast  <= n_fast;
            r_out_slow  <= n_slow;
            r_out_trend <= n_trend;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out_trend, r_out_slow, r_out_fast, r_out_held};

endmodule

`default_nettype wire

// ===== hdl/matd_checker.sv =====
// port-level assertions for the motion amplitude trend detector, bound to the top level
// depends on matd_pkg and assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module matd_checker (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              o_s_axis_tready,
    input  wire logic                              o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    input  wire logic [matd_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata
);

    logic [15:0] fast_f;
    logic [15:0] slow_f;
    logic [1:0]  trend_f;

    // result fields
    assign fast_f  = o_m_axis_tdata[31:16];
    assign slow_f  = o_m_axis_tdata[47:32];
    assign trend_f = o_m_axis_tdata[49:48];

    // a stalled result keeps its data
    `ASSERT_SYNC(a_out_hold, i_clk, i_rst_n, o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata), "stalled result changed")

    // with the result stage empty the input side must take a request
    `ASSERT_SYNC(a_ready_when_empty, i_clk, i_rst_n, !o_m_axis_tvalid |-> o_s_axis_tready, "input not ready with empty result stage")

    // approaching means the fast average is above the slow one
    `ASSERT_SYNC(a_approach_order, i_clk, i_rst_n, o_m_axis_tvalid && trend_f == matd_pkg::TREND_APPROACH |-> fast_f > slow_f, "approach without fast above slow")

    // receding means the fast average is below the slow one
    `ASSERT_SYNC(a_recede_order, i_clk, i_rst_n, o_m_axis_tvalid && trend_f == matd_pkg::TREND_RECEDE |-> fast_f < slow_f, "recede without fast below slow")

    // reset empties the result stage
    `ASSERT_ALWAYS(a_reset_clears, i_clk, !i_rst_n |=> !o_m_axis_tvalid, "result valid right after reset")

endmodule

bind motion_amplitude_trend_detector matd_checker u_matd_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

// ===== tb/tb.sv =====
// self-checking testbench for the motion amplitude trend detector
// predicts every result in a small scoreboard class; depends on matd_pkg and the block
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 300;
    localparam int TIMEOUT_NS    = 8_000_000;
    localparam int FULL_SCALE    = (1 << matd_pkg::SAMPLE_BITS) - 1;

    // one result as it appears on the output bus, held amplitude in the low bits
    typedef struct packed {
        logic [matd_pkg::OUT_TDATA_W-matd_pkg::SAMPLE_BITS*3-2-1:0] pad;
        matd_pkg::t_trend                                         trend;
        logic [matd_pkg::SAMPLE_BITS-1:0]                         slow_average;
        logic [matd_pkg::SAMPLE_BITS-1:0]                         fast_average;
        logic [matd_pkg::SAMPLE_BITS-1:0]                         held_amplitude;
    } t_amp_result;

    typedef enum {SEQ_NOISE, SEQ_DECAY, SEQ_RAMP} t_seq_kind;
    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_CYCLIC} t_rx_mode;

    // peak hold and trend predictor with its queue of expected results
    class amplitude_scoreboard;
        logic [matd_pkg::SAMPLE_BITS-1:0] up_margin, down_margin, init_step, step_inc;
        logic [matd_pkg::LIMIT_W-1:0]     fall_limit;
        logic [matd_pkg::SAMPLE_BITS-1:0] held, step, fast_avg, slow_avg;
        logic [matd_pkg::COUNT_W-1:0]     falls;
        t_amp_result                      expected_q[$];
        int                               errors;

        function new();
            up_margin   = matd_pkg::RST_UP_MARGIN;
            down_margin = matd_pkg::RST_DOWN_MARGIN;
            init_step   = matd_pkg::RST_INIT_STEP;
            step_inc    = matd_pkg::RST_STEP_INC;
            fall_limit  = matd_pkg::RST_FALL_LIMIT;
            held        = '0;
            step        = matd_pkg::RST_INIT_STEP;
            falls       = '0;
            fast_avg    = '0;
            slow_avg    = '0;
            errors      = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void write_reg(logic [matd_pkg::CFG_IDX_W-1:0] idx,
                                logic [matd_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                matd_pkg::REG_UP_MARGIN:   up_margin   = data;
                matd_pkg::REG_DOWN_MARGIN: down_margin = data;
                matd_pkg::REG_INIT_STEP:   init_step   = data;
                matd_pkg::REG_STEP_INC:    step_inc    = data;
                matd_pkg::REG_FALL_LIMIT:  fall_limit  = data[matd_pkg::LIMIT_W-1:0];
                default: ;
            endcase
        endfunction

        // accepted request: advance the peak hold and averages, queue the result
        function void note_request(logic [matd_pkg::IN_TDATA_W-1:0] tdata);
            int unsigned hi, lo, amp, grown, fast_w, slow_w;
            t_amp_result res;
            hi = tdata[matd_pkg::SAMPLE_BITS-1:0];
            lo = tdata[2*matd_pkg::SAMPLE_BITS-1:matd_pkg::SAMPLE_BITS];
            amp = (hi >= lo) ? hi - lo : lo - hi;
            if (amp >= held) begin
                held  = amp[matd_pkg::SAMPLE_BITS-1:0];
                step  = init_step;
                falls = '0;
            end else if (held >= step) begin
                held = held - step;
                if (falls != '1)
                    falls = falls + 1'b1;
                if (falls > fall_limit) begin
                    grown = step + step_inc;
                    step = (grown > FULL_SCALE) ? FULL_SCALE
                                                : grown[matd_pkg::SAMPLE_BITS-1:0];
                end
            end else begin
                held = '0;
            end
            fast_w = (fast_avg * 3 + held) / 4;
            slow_w = (slow_avg * 15 + held) / 16;
            fast_avg = fast_w[matd_pkg::SAMPLE_BITS-1:0];
            slow_avg = slow_w[matd_pkg::SAMPLE_BITS-1:0];
            res = '0;
            res.held_amplitude = held;
            res.fast_average   = fast_avg;
            res.slow_average   = slow_avg;
            if (fast_w > slow_w + up_margin)
                res.trend = matd_pkg::TREND_APPROACH;
            else if (fast_w + down_margin < slow_w)
                res.trend = matd_pkg::TREND_RECEDE;
            else
                res.trend = matd_pkg::TREND_STABLE;
            expected_q.push_back(res);
        endfunction

        function void compare_field(string label, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t mismatch %s: expected %0h, actual %0h", $time, label, want, got);
            end
        endfunction

        function void check_result(logic [matd_pkg::OUT_TDATA_W-1:0] tdata);
            t_amp_result got, want;
            got = tdata;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t mismatch unexpected result: expected none, actual %0h",
                         $time, tdata);
            end else begin
                want = expected_q.pop_front();
                compare_field("held_amplitude", want.held_amplitude, got.held_amplitude);
                compare_field("fast_average", want.fast_average, got.fast_average);
                compare_field("slow_average", want.slow_average, got.slow_average);
                compare_field("trend", want.trend, got.trend);
                compare_field("pad", want.pad, got.pad);
            end
        endfunction
    endclass

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_we;
    logic [matd_pkg::CFG_IDX_W-1:0]   i_cfg_idx;
    logic [matd_pkg::CFG_DATA_W-1:0]  i_cfg_wdata;
    logic                             i_s_axis_tvalid;
    logic                             o_s_axis_tready;
    // [15:0] window_max, [31:16] window_min
    logic [matd_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata;
    logic                             o_m_axis_tvalid;
    logic                             i_m_axis_tready;
    // [15:0] held_amplitude, [31:16] fast_average, [47:32] slow_average,
    // [49:48] trend, [55:50] zero
    logic [matd_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata;

    amplitude_scoreboard sb = new();
    bit hold_req    = 1'b0;
    int burst_left  = 0;
    int steady_left = 0;

    motion_amplitude_trend_detector dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // watch both handshakes and the register port at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_cfg_we)
                sb.write_reg(i_cfg_idx, i_cfg_wdata);
            if (i_s_axis_tvalid && o_s_axis_tready)
                sb.note_request(i_s_axis_tdata);
            if (o_m_axis_tvalid && i_m_axis_tready)
                sb.check_result(o_m_axis_tdata);
        end
    end

    // receiver: stall pattern in random segments, plus long hold-offs on demand
    initial begin : rx_side
        t_rx_mode mode;
        int seg_left, beat;
        i_m_axis_tready = 1'b0;
        mode = RX_OPEN;
        seg_left = 0;
        beat = 0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                i_m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (seg_left == 0) begin
                mode = t_rx_mode'($urandom_range(0, 3));
                seg_left = $urandom_range(10, 150);
                beat = 0;
            end
            seg_left--;
            beat++;
            case (mode)
                RX_OPEN:   i_m_axis_tready <= 1'b1;
                RX_COIN:   i_m_axis_tready <= 1'($urandom_range(0, 1));
                RX_SPARSE: i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                default:   i_m_axis_tready <= (beat % 3) != 0;
            endcase
        end
    end

    task automatic idle(input int cycles);
        i_s_axis_tvalid <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    // offer one request, wait for its handshake, then maybe leave a gap
    task automatic send_window(input logic [15:0] wmax, input logic [15:0] wmin);
        i_s_axis_tdata  <= {wmin, wmax};
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        @(negedge i_clk);
        if (steady_left > 0) begin
            steady_left--;
        end else if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            if ($urandom_range(0, 3) != 0)
                idle($urandom_range(1, 12));
        end else begin
            burst_left--;
        end
    endtask

    // window with a given amplitude at a random level, extremes in random order
    task automatic send_amp(input int unsigned amp);
        int unsigned base;
        base = $urandom_range(0, FULL_SCALE - amp);
        if ($urandom_range(0, 1))
            send_window(16'(base + amp), 16'(base));
        else
            send_window(16'(base), 16'(base + amp));
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [matd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [matd_pkg::CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(negedge i_clk);
    endtask

    task automatic configure(input logic [15:0] up, down, init, inc, lim_raw);
        cfg_write(matd_pkg::REG_UP_MARGIN, up);
        cfg_write(matd_pkg::REG_DOWN_MARGIN, down);
        cfg_write(matd_pkg::REG_INIT_STEP, init);
        cfg_write(matd_pkg::REG_STEP_INC, inc);
        cfg_write(matd_pkg::REG_FALL_LIMIT, lim_raw);
        i_cfg_we <= 1'b0;
    endtask

    // register value biased toward the extremes
    function automatic logic [15:0] pick_reg16(input int unsigned low_max);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return 16'hFFFF;
            2, 3:    return 16'($urandom_range(0, low_max));
            default: return 16'($urandom_range(0, FULL_SCALE));
        endcase
    endfunction

    function automatic logic [15:0] pick_limit();
        case ($urandom_range(0, 4))
            0:       return '0;
            1:       return 16'h00FF;
            2:       return 16'($urandom_range(0, 20));
            3:       return 16'($urandom_range(0, FULL_SCALE));
            default: return 16'($urandom_range(1, 40));
        endcase
    endfunction

    // mostly peaks followed by decays, with ramps and noise in between
    task automatic run_random(input int n_items);
        t_seq_kind kind;
        int seq_left, k, pick;
        int unsigned tail_max, ramp_amp;
        kind = SEQ_NOISE;
        seq_left = 0;
        k = 0;
        tail_max = 0;
        ramp_amp = 0;
        while (k < n_items) begin
            if (seq_left == 0) begin
                pick = $urandom_range(0, 9);
                if (pick < 2) begin
                    kind = SEQ_NOISE;
                    seq_left = $urandom_range(1, 10);
                end else if (pick < 8) begin
                    kind = SEQ_DECAY;
                    seq_left = $urandom_range(5, 80);
                    tail_max = $urandom_range(0, 1) ? 0 : $urandom_range(1, 300);
                    send_amp($urandom_range(2000, FULL_SCALE));
                    k++;
                end else begin
                    kind = SEQ_RAMP;
                    seq_left = $urandom_range(3, 15);
                    ramp_amp = $urandom_range(0, 3000);
                end
            end else begin
                case (kind)
                    SEQ_NOISE: send_window(16'($urandom_range(0, FULL_SCALE)),
                                           16'($urandom_range(0, FULL_SCALE)));
                    SEQ_DECAY: send_amp($urandom_range(0, tail_max));
                    default: begin
                        ramp_amp = ramp_amp + $urandom_range(0, 2000);
                        if (ramp_amp > FULL_SCALE)
                            ramp_amp = FULL_SCALE;
                        send_amp(ramp_amp);
                    end
                endcase
                seq_left--;
                k++;
            end
        end
    endtask

    // run limit
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("FAIL");
        $finish;
    end

    initial begin : stimulus
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_idx       = '0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: zero, full scale both ways, swapped extremes, small falls
        send_window(16'h0000, 16'h0000);
        send_window(16'hFFFF, 16'h0000);
        send_window(16'h0000, 16'hFFFF);
        send_window(16'hFFFF, 16'hFFFF);
        send_window(16'h8000, 16'h7FFF);
        send_window(16'h1234, 16'h1234);
        drain();

        // zero margins; decay step saturates on its first growth, then clear below step
        configure(16'h0000, 16'h0000, 16'h8000, 16'h9000, 16'h0000);
        send_window(16'hFFFF, 16'h0000);
        send_window(16'h0000, 16'hFFFF);
        send_window(16'hFFFF, 16'h0000);
        send_window(16'h0000, 16'h0000);
        send_window(16'h0000, 16'h0000);
        send_window(16'h0000, 16'h0000);
        send_window(16'h0000, 16'h0000);
        send_window(16'h0001, 16'h0000);
        send_window(16'h0000, 16'h0000);
        drain();

        // writes to unused indexes are dropped; fall limit keeps only its low byte
        for (int r = int'(matd_pkg::REG_FALL_LIMIT) + 1; r < (1 << matd_pkg::CFG_IDX_W); r++)
            cfg_write(matd_pkg::t_reg_idx'(r), 16'($urandom_range(0, FULL_SCALE)));
        configure(16'h0005, 16'hFFFF, 16'h0001, 16'h0001, 16'hAB00);
        send_window(16'd100, 16'd0);
        send_window(16'd0, 16'd0);
        send_window(16'd0, 16'd0);
        send_window(16'd5, 16'd5);
        send_window(16'd0, 16'd0);
        drain();

        // zero step: long run of falls takes the fall count to its ceiling
        configure(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'h00FF);
        send_window(16'hFFFF, 16'h0000);
        for (int j = 0; j < 560; j++)
            send_amp($urandom_range(0, FULL_SCALE - 1));
        drain();
        // saturated count keeps the step growing once it has an increment
        cfg_write(matd_pkg::REG_STEP_INC, 16'h0001);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
        for (int j = 0; j < 40; j++)
            send_amp($urandom_range(0, 60000));
        drain();

        // random settings, each phase opening with a long receiver hold-off
        for (int p = 0; p < 7; p++) begin
            configure(pick_reg16(200), pick_reg16(200), pick_reg16(50), pick_reg16(50),
                      pick_limit());
            @(negedge i_clk);
            hold_req = 1'b1;
            steady_left = 30;
            run_random(190);
            drain();
        end

        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
